/* rtl/gmbf_pkg.sv */
// shared types and constants for the multi-source grid flood
`timescale 1ns / 1ps
`default_nettype none

package gmbf_pkg;

    // default grid capacity
    localparam int MAX_ROWS_DEF = 128;
    localparam int MAX_COLS_DEF = 128;

    // field and register widths
    localparam int COORD_W = 8;
    localparam int CFG_W   = 8;
    localparam int DATA_W  = 2 * COORD_W;

    // configuration register indexes
    localparam logic CFG_GRID_ROWS = 1'b0;
    localparam logic CFG_GRID_COLS = 1'b1;

    // register values after reset
    localparam logic [CFG_W-1:0] GRID_ROWS_RST = 8'd128;
    localparam logic [CFG_W-1:0] GRID_COLS_RST = 8'd128;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_POP,
        ST_CELL,
        ST_NB,
        ST_CHK,
        ST_DONE
    } state_t;

    // neighbour order: column+1, column-1, row-1, row+1
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

endpackage

`default_nettype wire

/* rtl/gmbf_ram.sv */
// simple dual-port synchronous ram, one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module gmbf_ram #(
    parameter int WIDTH  = 1,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read-first registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/grid_multi_source_bfs_farthest.sv */
// top level: multi-source breadth-first flood on a grid, reports the farthest cell
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+---------------------------------------------
// s_*      | in  | s_tvalid/s_tready  | s_tdata: src_row, src_col; s_tlast: last_source
// m_*      | out | m_tvalid/m_tready  | m_tdata: far_row, far_col; m_tuser: no_source
// cfg_*    | in  | cfg_we             | cfg_addr: register index; cfg_wdata: value
//
// sources load one item per cycle through a read-modify-write of the visited map,
// with forwarding of the previous cycle's mark to cover back-to-back duplicates
// flood: each dequeued cell takes a pop state and a cell state, then per neighbour
// a neighbour state, plus a check state for an in-grid one (visited read then mark);
// the single registered read port of the visited map sets this sequence
// after reset and after each result a clearing pass writes all of the
// 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) visited entries (16384 by default), no input taken
// the result waits in an output register; the next run can load meanwhile
`timescale 1ns / 1ps
`default_nettype none

module grid_multi_source_bfs_farthest #(
    parameter int MAX_ROWS = gmbf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gmbf_pkg::MAX_COLS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // sources
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [gmbf_pkg::DATA_W-1:0]  s_tdata,   // src_row [7:0], src_col [15:8]
    input  wire logic                         s_tlast,   // last_source
    // results
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [gmbf_pkg::DATA_W-1:0]  m_tdata,   // far_row [7:0], far_col [15:8]
    output logic                              m_tuser,   // no_source
    // configuration writes
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_addr,
    input  wire logic [gmbf_pkg::CFG_W-1:0]   cfg_wdata
);

    import gmbf_pkg::*;

    // coordinate and address widths
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int VDEPTH = 1 << AW;
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int QA    = $clog2(CELLS);
    localparam int QW    = $clog2(CELLS + 1);
    localparam int MW    = (RW > CW) ? RW : CW;
    // wide enough for a one-based value and for a wrapped minus one
    localparam int XW    = ((MW > COORD_W) ? MW : COORD_W) + 1;

    // configuration
    logic [CFG_W-1:0] grid_rows_reg;
    logic [CFG_W-1:0] grid_cols_reg;

    // control
    state_t           state_reg, state_next;
    dir_t             dir_reg, dir_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [QW-1:0]    head_reg, head_next;
    logic [QW-1:0]    tail_reg, tail_next;
    logic [AW-1:0]    last_reg, last_next;
    logic [AW-1:0]    cur_reg, cur_next;

    // source pipeline stage (visited read in flight)
    logic             p_valid_reg, p_valid_next;
    logic [AW-1:0]    p_addr_reg, p_addr_next;
    logic             p_inb_reg, p_inb_next;
    logic             p_last_reg, p_last_next;

    // mark written last cycle, forwarded over the read-first ram
    logic             fw_valid_reg, fw_valid_next;
    logic [AW-1:0]    fw_addr_reg, fw_addr_next;

    // output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [COORD_W-1:0] far_row_reg, far_row_next;
    logic [COORD_W-1:0] far_col_reg, far_col_next;
    logic             no_src_reg, no_src_next;

    // memory ports
    logic             vis_we;
    logic [AW-1:0]    vis_waddr;
    logic             vis_wdata;
    logic [AW-1:0]    vis_raddr;
    logic             vis_rdata;
    logic             q_we;
    logic [QA-1:0]    q_waddr;
    logic [AW-1:0]    q_wdata;
    logic [QA-1:0]    q_raddr;
    logic [AW-1:0]    q_rdata;

    // datapath
    logic             accept;
    logic [XW-1:0]    src_r, src_c;
    logic             src_inb;
    logic [AW-1:0]    src_addr;
    logic [XW-1:0]    nb_r, nb_c;
    logic             nb_inb;
    logic [AW-1:0]    nb_addr;
    logic             room;
    logic             seen;
    logic [XW-1:0]    far_r, far_c;

    function automatic logic in_grid(
        input logic [XW-1:0]    r,
        input logic [XW-1:0]    c,
        input logic [CFG_W-1:0] rows,
        input logic [CFG_W-1:0] cols
    );
        in_grid = (r < XW'(rows)) && (r < XW'(MAX_ROWS)) &&
                  (c < XW'(cols)) && (c < XW'(MAX_COLS));
    endfunction

    gmbf_ram #(
        .WIDTH  (1),
        .DEPTH  (VDEPTH),
        .ADDR_W (AW)
    ) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    gmbf_ram #(
        .WIDTH  (AW),
        .DEPTH  (CELLS),
        .ADDR_W (QA)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= GRID_ROWS_RST;
            grid_cols_reg <= GRID_COLS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_GRID_ROWS: grid_rows_reg <= cfg_wdata;
                CFG_GRID_COLS: grid_cols_reg <= cfg_wdata;
                default:       grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    // source decode: one-based, a zero coordinate wraps and fails the bound check
    assign src_r    = XW'(s_tdata[COORD_W-1:0]) - XW'(1);
    assign src_c    = XW'(s_tdata[DATA_W-1:COORD_W]) - XW'(1);
    assign src_inb  = in_grid(src_r, src_c, grid_rows_reg, grid_cols_reg);
    assign src_addr = {src_r[RW-1:0], src_c[CW-1:0]};

    // neighbour of the current cell in the current direction
    always_comb
    begin
        nb_r = XW'(cur_reg[AW-1:CW]);
        nb_c = XW'(cur_reg[CW-1:0]);
        case (dir_reg)
            DIR_RIGHT: nb_c = XW'(cur_reg[CW-1:0]) + XW'(1);
            DIR_LEFT:  nb_c = XW'(cur_reg[CW-1:0]) - XW'(1);
            DIR_UP:    nb_r = XW'(cur_reg[AW-1:CW]) - XW'(1);
            DIR_DOWN:  nb_r = XW'(cur_reg[AW-1:CW]) + XW'(1);
            default:   nb_c = XW'(cur_reg[CW-1:0]);
        endcase
    end

    assign nb_inb  = in_grid(nb_r, nb_c, grid_rows_reg, grid_cols_reg);
    assign nb_addr = {nb_r[RW-1:0], nb_c[CW-1:0]};

    assign room   = tail_reg < QW'(CELLS);
    assign seen   = vis_rdata || (fw_valid_reg && (fw_addr_reg == p_addr_reg));
    assign far_r  = XW'(last_reg[AW-1:CW]) + XW'(1);
    assign far_c  = XW'(last_reg[CW-1:0]) + XW'(1);

    // input is held off once a last source is in flight
    assign s_tready = (state_reg == ST_LOAD) && !(p_valid_reg && p_last_reg);
    assign accept   = s_tvalid && s_tready;

    // next state and memory control
    always_comb
    begin
        state_next    = state_reg;
        dir_next      = dir_reg;
        clr_next      = clr_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        last_next     = last_reg;
        cur_next      = cur_reg;
        p_valid_next  = 1'b0;
        p_addr_next   = p_addr_reg;
        p_inb_next    = p_inb_reg;
        p_last_next   = p_last_reg;
        fw_valid_next = 1'b0;
        fw_addr_next  = fw_addr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        far_row_next  = far_row_reg;
        far_col_next  = far_col_reg;
        no_src_next   = no_src_reg;
        vis_we        = 1'b0;
        vis_waddr     = p_addr_reg;
        vis_wdata     = 1'b1;
        vis_raddr     = src_addr;
        q_we          = 1'b0;
        q_waddr       = tail_reg[QA-1:0];
        q_wdata       = p_addr_reg;
        q_raddr       = head_reg[QA-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
                vis_wdata = 1'b0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                if (accept)
                begin
                    p_valid_next = 1'b1;
                    p_addr_next  = src_addr;
                    p_inb_next   = src_inb;
                    p_last_next  = s_tlast;
                end
                // map data for the item taken last cycle is here now
                if (p_valid_reg)
                begin
                    if (p_inb_reg && !seen && room)
                    begin
                        vis_we        = 1'b1;
                        q_we          = 1'b1;
                        tail_next     = tail_reg + QW'(1);
                        last_next     = p_addr_reg;
                        fw_valid_next = 1'b1;
                        fw_addr_next  = p_addr_reg;
                    end
                    if (p_last_reg)
                    begin
                        state_next = ST_POP;
                    end
                end
            end

            ST_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    head_next  = head_reg + QW'(1);
                    state_next = ST_CELL;
                end
            end

            ST_CELL:
            begin
                cur_next   = q_rdata;
                dir_next   = DIR_RIGHT;
                state_next = ST_NB;
            end

            ST_NB:
            begin
                vis_raddr = nb_addr;
                if (nb_inb)
                begin
                    state_next = ST_CHK;
                end
                else if (dir_reg == DIR_DOWN)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    dir_next = dir_t'(dir_reg + 2'd1);
                end
            end

            ST_CHK:
            begin
                if (!vis_rdata && room)
                begin
                    vis_we    = 1'b1;
                    vis_waddr = nb_addr;
                    q_we      = 1'b1;
                    q_wdata   = nb_addr;
                    tail_next = tail_reg + QW'(1);
                    last_next = nb_addr;
                end
                if (dir_reg == DIR_DOWN)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    dir_next   = dir_t'(dir_reg + 2'd1);
                    state_next = ST_NB;
                end
            end

            ST_DONE:
            begin
                // wait for the previous result to leave the output register
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    no_src_next   = (tail_reg == '0);
                    far_row_next  = (tail_reg == '0) ? '0 : far_r[COORD_W-1:0];
                    far_col_next  = (tail_reg == '0) ? '0 : far_c[COORD_W-1:0];
                    head_next     = '0;
                    tail_next     = '0;
                    last_next     = '0;
                    clr_next      = '0;
                    state_next    = ST_CLEAR;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            dir_reg      <= DIR_RIGHT;
            clr_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            last_reg     <= '0;
            p_valid_reg  <= 1'b0;
            p_last_reg   <= 1'b0;
            fw_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dir_reg      <= dir_next;
            clr_reg      <= clr_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            last_reg     <= last_next;
            p_valid_reg  <= p_valid_next;
            p_last_reg   <= p_last_next;
            fw_valid_reg <= fw_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        p_addr_reg  <= p_addr_next;
        p_inb_reg   <= p_inb_next;
        fw_addr_reg <= fw_addr_next;
        far_row_reg <= far_row_next;
        far_col_reg <= far_col_next;
        no_src_reg  <= no_src_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {far_col_reg, far_row_reg};
    assign m_tuser  = no_src_reg;

    // the queue never reads past what has been written
    a_head_behind_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    // a last source closes the input until the run is flooded and cleared
    a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> !s_tready)
        else $error("input taken after last source");

    // every newly marked neighbour is queued
    a_mark_enqueues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK && vis_we) |=> (tail_reg == $past(tail_reg) + QW'(1)))
        else $error("marked cell not queued");

    // no result is produced while loading sources
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result outside done state");

endmodule

`default_nettype wire
